// File: src/lcd_decimal_nibble_writer_macros.svh
`ifndef LCD_DECIMAL_NIBBLE_WRITER_MACROS_SVH
`define LCD_DECIMAL_NIBBLE_WRITER_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define LDNW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcd_decimal_nibble_writer: check failed");

// next-cycle implication, checked on clk outside reset
`define LDNW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcd_decimal_nibble_writer: check failed");

`endif

// File: src/ldnw_pkg.sv
`timescale 1ns / 1ps

package ldnw_pkg;

  localparam int NUM_BITS = 32;
  localparam int DIGITS   = 10;
  localparam int PTR_W    = $clog2(DIGITS);
  localparam int CNT_W    = $clog2(NUM_BITS);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [1:0] {
    REQ_NUMBER  = 2'd0,
    REQ_COMMAND = 2'd1,
    REQ_CHAR    = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load_num;
    logic load_code;
    logic code_is_data;
    logic convert;
    logic scan_dec;
    logic first_char;
    logic emit;
    logic next_char;
  } ctl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic phase_end;
    logic more;
  } ctl_stat_t;

endpackage

// File: src/ldnw_datapath.sv
`timescale 1ns / 1ps

module ldnw_datapath
  import ldnw_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_cmd_t                   cmd,
  output ctl_stat_t                  stat,
  input  logic signed [NUM_BITS-1:0] number,
  input  logic [7:0]                 code_byte,
  output logic [7:0]                 expander_byte,
  output logic                       last,
  output logic                       strobe
);

  logic [NUM_BITS-1:0]  mag;
  logic [DIGITS-1:0][3:0] bcd;
  logic [DIGITS-1:0][3:0] bcd_adj;
  logic [CNT_W-1:0]     bit_cnt;
  logic [PTR_W-1:0]     ptr;
  logic [PTR_W-1:0]     sel_ptr;
  logic [1:0]           phase;
  logic [7:0]           cur;
  logic                 is_data;
  logic                 neg;
  logic                 num_mode;
  logic                 sign_stage;
  logic [3:0]           digit;
  logic [7:0]           digit_char;
  logic [7:0]           next_digit_char;
  logic [3:0]           nibble;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  // after the sign the pointer already sits on the first digit
  assign sel_ptr         = sign_stage ? ptr : ptr - PTR_W'(1);
  assign digit           = bcd[ptr];
  assign digit_char      = ASCII_ZERO + {4'h0, digit};
  assign next_digit_char = ASCII_ZERO + {4'h0, bcd[sel_ptr]};
  assign nibble          = phase[1] ? cur[3:0] : cur[7:4];

  assign stat.conv_done = (bit_cnt == CNT_W'(NUM_BITS - 1));
  assign stat.lead_zero = (digit == 4'd0) && (ptr != '0);
  assign stat.phase_end = (phase == 2'd3);
  assign stat.more      = num_mode && (sign_stage || ptr != '0);

  always_ff @(posedge clk) begin
    if (cmd.load_num) begin
      neg      <= number[NUM_BITS-1];
      mag      <= number[NUM_BITS-1] ? NUM_BITS'(-number) : NUM_BITS'(number);
      bcd      <= '0;
      bit_cnt  <= '0;
      ptr      <= PTR_W'(DIGITS - 1);
      num_mode <= 1'b1;
      is_data  <= 1'b1;
    end
    if (cmd.load_code) begin
      cur        <= code_byte;
      is_data    <= cmd.code_is_data;
      num_mode   <= 1'b0;
      sign_stage <= 1'b0;
    end
    if (cmd.convert) begin
      {bcd, mag} <= {bcd_adj, mag} << 1;
      bit_cnt    <= bit_cnt + CNT_W'(1);
    end
    if (cmd.scan_dec) begin
      ptr <= ptr - PTR_W'(1);
    end
    if (cmd.first_char) begin
      sign_stage <= neg;
      cur        <= neg ? ASCII_MINUS : digit_char;
    end
    if (cmd.next_char) begin
      cur        <= next_digit_char;
      sign_stage <= 1'b0;
      ptr        <= sel_ptr;
    end
    if (cmd.load_num || cmd.load_code) begin
      phase <= 2'd0;
    end else if (cmd.emit) begin
      phase <= phase + 2'd1;
    end
    if (cmd.emit) begin
      expander_byte <= {nibble, 1'b1, ~phase[0], 1'b0, is_data};
      last          <= stat.phase_end && !stat.more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

endmodule

// File: src/ldnw_ctrl.sv
`timescale 1ns / 1ps

module ldnw_ctrl
  import ldnw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] req_type,
  input  ctl_stat_t  stat,
  output ctl_cmd_t   cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (req_t'(req_type))
            REQ_NUMBER: begin
              cmd.load_num = 1'b1;
              state_next   = ST_CONVERT;
            end
            REQ_COMMAND: begin
              cmd.load_code = 1'b1;
              state_next    = ST_EMIT;
            end
            REQ_CHAR: begin
              cmd.load_code    = 1'b1;
              cmd.code_is_data = 1'b1;
              state_next       = ST_EMIT;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONVERT: begin
        cmd.convert = 1'b1;
        if (stat.conv_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.lead_zero) begin
          cmd.scan_dec = 1'b1;
        end else begin
          cmd.first_char = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.phase_end) begin
          if (stat.more) begin
            cmd.next_char = 1'b1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/lcd_decimal_nibble_writer.sv
`timescale 1ns / 1ps
// Turns one request into expander bytes for a 4-bit character display:
// a signed decimal number, a command byte or a character byte. Each display
// byte goes out as four bytes (high nibble with enable set, then clear, then
// the low nibble likewise), one per cycle on expander_byte with strobe high
// for that single cycle; last marks the final byte of the transaction. The
// receiver cannot stall, so it must take a byte in every strobe cycle.
// A command or character keeps busy high while its four bytes go out. A
// number keeps it high through the binary-to-BCD conversion (one bit a
// cycle), a scan past the leading zero digits, then the printed characters
// (sign plus digits), each sent as four bytes. Output bytes appear in the
// cycle after the internal sequencer emits them. Request type 3 is accepted
// and produces nothing.

`include "lcd_decimal_nibble_writer_macros.svh"

module lcd_decimal_nibble_writer
  import ldnw_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 req_type,
  input  logic signed [NUM_BITS-1:0] number,
  input  logic [7:0]                 code_byte,
  output logic                       strobe,
  output logic [7:0]                 expander_byte,
  output logic                       last
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  ldnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  ldnw_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .number        (number),
    .code_byte     (code_byte),
    .expander_byte (expander_byte),
    .last          (last),
    .strobe        (strobe)
  );

  `LDNW_ASSERT_NOW(a_last_when_idle, strobe && last, !busy)
  `LDNW_ASSERT_NEXT(a_gap_after_last, strobe && last, !strobe)
  `LDNW_ASSERT_NEXT(a_stream_unbroken, strobe && !last, strobe)
  `LDNW_ASSERT_NEXT(a_unused_type_idle, start && !busy && req_type == REQ_UNUSED, !busy)

endmodule
